/* src/pte_pkg.sv */
// Package with shared types, constants and helper functions of the particle table engine.
`timescale 1ns / 1ps
package pte_pkg;

	localparam int DefaultSlots = 64;
	localparam logic [15:0] RandomSeed = 16'hACE1;
	localparam logic [11:0] WidthReset = 12'd320;
	localparam logic [11:0] HeightReset = 12'd240;

	typedef enum logic [1:0] {
		REQ_BURST = 2'd0,
		REQ_TICK = 2'd1,
		REQ_DRAW = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPREAD,
		ST_SPAWN,
		ST_SWEEP,
		ST_FLUSH,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] vel_x;
		logic [15:0] vel_y;
		logic [4:0] life;
		logic [4:0] start;
		logic [7:0] ramp;
	} particle_t;

	function automatic logic [15:0] xorshift(input logic [15:0] x);
		logic [15:0] a;
		logic [15:0] b;
		a = x ^ (x << 7);
		b = a ^ (a >> 9);
		return b ^ (b << 8);
	endfunction

	function automatic logic signed [7:0] dir_x(input logic [3:0] idx);
		logic signed [7:0] v;
		case (idx)
			4'd0: v = 8'sd64;
			4'd1: v = 8'sd59;
			4'd2: v = 8'sd45;
			4'd3: v = 8'sd24;
			4'd4: v = 8'sd0;
			4'd5: v = -8'sd24;
			4'd6: v = -8'sd45;
			4'd7: v = -8'sd59;
			4'd8: v = -8'sd64;
			4'd9: v = -8'sd59;
			4'd10: v = -8'sd45;
			4'd11: v = -8'sd24;
			4'd12: v = 8'sd0;
			4'd13: v = 8'sd24;
			4'd14: v = 8'sd45;
			4'd15: v = 8'sd59;
			default: v = 8'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [7:0] dir_y(input logic [3:0] idx);
		return dir_x(idx - 4'd4);
	endfunction

	// Fade step (start - life) * 8 / (start + 1) for 5-bit operands.
	function automatic logic [7:0] fade_step(input logic [4:0] start, input logic [4:0] life);
		logic [8:0] num;
		logic [5:0] den;
		logic [3:0] q;
		num = 9'(({4'd0, start} - {4'd0, life}) << 3);
		den = {1'b0, start} + 6'd1;
		q = 4'd0;
		for (int k = 1; k <= 8; k++) begin
			if (num >= 9'(den * k)) begin
				q = 4'(k);
			end
		end
		return {4'd0, q};
	endfunction

endpackage

/* src/pte_spawn.sv */
// Spawn datapath: random draw, speed modulo stepping and velocity products.
`timescale 1ns / 1ps
module pte_spawn
	import pte_pkg::*;
(
	input  logic        clk,
	input  logic [15:0] rnd,
	input  logic [7:0]  spread,
	input  logic        mod_load,
	output logic        mod_done,
	output logic signed [15:0] vel_x,
	output logic signed [15:0] vel_y,
	output logic [4:0]  life
);

	logic [11:0] rem_q;
	logic [7:0]  div_q;
	logic [8:0]  spd;
	logic signed [17:0] px;
	logic signed [17:0] py;

	always_ff @(posedge clk) begin
		if (mod_load) begin
			rem_q <= rnd[15:4];
			div_q <= (spread == 8'd0) ? 8'd1 : spread;
		end else if (rem_q >= {4'd0, div_q}) begin
			rem_q <= rem_q - {4'd0, div_q};
		end
	end

	assign mod_done = rem_q < {4'd0, div_q};
	assign spd = 9'd12 + {1'b0, rem_q[7:0]};
	assign px = dir_x(rnd[3:0]) * $signed({1'b0, spd});
	assign py = dir_y(rnd[3:0]) * $signed({1'b0, spd});
	assign vel_x = 16'(px >>> 6);
	assign vel_y = 16'(py >>> 6) - 16'sd14;
	assign life = 5'd10 + {1'b0, rnd[12:9]};

endmodule

/* src/pte_table.sv */
// Particle table memory with one synchronous read port and one write port.
`timescale 1ns / 1ps
module pte_table
	import pte_pkg::*;
#(
	parameter int Slots = DefaultSlots
) (
	input  logic                     clk,
	input  logic [$clog2(Slots)-1:0] rd_addr,
	output particle_t                rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(Slots)-1:0] wr_addr,
	input  particle_t                wr_data
);

	particle_t mem [Slots];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* src/particle_table_engine.sv */
// Top level of the particle table engine: control sequencer, registers and result output.
// Usage: pulse start with req_type and burst fields while busy is low; the item is
// taken at that edge and busy rises until the work is done. Screen size is written
// through the APB port (word 0 width, word 1 height) while the block is idle.
// A burst passes through SPREAD and then SPAWN for each particle; SPAWN subtracts
// the spread from a 12-bit random remainder until the remainder is below the spread,
// with a spread of zero counted as one. Tick and draw each sweep the table memory
// once and then flush, an empty draw adding one EMPTY step; a clearing sweep follows reset.
// Draw results appear on visible, pixel_x, pixel_y, dot_color, dot_size and last with
// strobe high for one cycle each, in slot order, and the last word carries last. A draw
// with nothing on screen gives one word with visible low. The receiver cannot stall;
// every word is delivered as it comes.
// After reset the table is swept once to clear every slot; busy stays high meanwhile.
// The table memory read port is the limit: one slot is read per cycle and written back when it changes.
`timescale 1ns / 1ps
module particle_table_engine
	import pte_pkg::*;
#(
	parameter int Slots = DefaultSlots
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic signed [11:0] spawn_x,
	input  logic signed [11:0] spawn_y,
	input  logic [7:0]  burst_count,
	input  logic [7:0]  color_ramp,
	input  logic [7:0]  speed_spread,
	output logic        strobe,
	output logic        visible,
	output logic [10:0] pixel_x,
	output logic [10:0] pixel_y,
	output logic [7:0]  dot_color,
	output logic [1:0]  dot_size,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(Slots);

	state_t state_q, state_d;
	logic [11:0] width_q, height_q;
	logic [15:0] rand_q;
	logic [AW-1:0] ins_q;
	logic [7:0] left_q;
	logic [AW:0] addr_q;
	logic clear_q;
	req_t req_q;
	logic signed [11:0] cx_q, cy_q;
	logic [7:0] ramp_q, spread_q;
	logic [15:0] rnd_next;
	logic mod_load, mod_done;
	logic signed [15:0] sp_vx, sp_vy;
	logic [4:0] sp_life;

	logic rd_valid_s1;
	logic [AW-1:0] rd_slot_s1;
	particle_t rd_data;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	particle_t wr_data;

	logic has_pend_q;
	logic [10:0] pend_x_q, pend_y_q;
	logic [7:0] pend_col_q;
	logic [1:0] pend_size_q;
	logic any_q;

	logic signed [11:0] fx, fy;
	logic on_screen;
	logic [6:0] l3, s1x, s2x;
	logic emit_now, sweep_end;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {20'd0, height_q} : {20'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WidthReset;
			height_q <= HeightReset;
		end else if (psel && penable && pwrite) begin
			if (paddr == 3'd0) begin
				width_q <= pwdata[11:0];
			end else if (paddr == 3'd4) begin
				height_q <= pwdata[11:0];
			end
		end
	end

	assign rnd_next = xorshift(rand_q);

	pte_spawn u_spawn (
		.clk(clk),
		.rnd(rand_q),
		.spread(spread_q),
		.mod_load(mod_load),
		.mod_done(mod_done),
		.vel_x(sp_vx),
		.vel_y(sp_vy),
		.life(sp_life)
	);

	pte_table #(.Slots(Slots)) u_table (
		.clk(clk),
		.rd_addr(addr_q[AW-1:0]),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign sweep_end = (addr_q == (AW+1)'(Slots));
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req_t'(req_type))
						REQ_BURST: state_d = (burst_count == 8'd0) ? ST_IDLE : ST_SPREAD;
						REQ_TICK, REQ_DRAW: state_d = ST_SWEEP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SPREAD: state_d = ST_SPAWN;
			ST_SPAWN: begin
				if (mod_done && left_q == 8'd1) begin
					state_d = ST_IDLE;
				end else if (mod_done) begin
					state_d = ST_SPREAD;
				end
			end
			ST_SWEEP: if (sweep_end) state_d = ST_FLUSH;
			ST_FLUSH: state_d = (req_q == REQ_DRAW && !clear_q && !any_q) ? ST_EMPTY : ST_IDLE;
			ST_EMPTY: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mod_load = (state_q == ST_SPREAD);
	end

	// The random word advances on entry to each spawn, so rand_q holds r in SPREAD/SPAWN.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			clear_q <= 1'b1;
			rand_q <= RandomSeed;
			ins_q <= '0;
			left_q <= '0;
			addr_q <= '0;
			req_q <= REQ_NONE;
			rd_valid_s1 <= 1'b0;
			rd_slot_s1 <= '0;
		end else begin
			state_q <= state_d;
			rd_valid_s1 <= (state_q == ST_SWEEP) && !sweep_end;
			rd_slot_s1 <= addr_q[AW-1:0];
			if (state_q == ST_IDLE && start) begin
				clear_q <= 1'b0;
				req_q <= req_t'(req_type);
				addr_q <= '0;
				left_q <= burst_count;
				if (req_t'(req_type) == REQ_BURST && burst_count != 8'd0) begin
					rand_q <= rnd_next;
				end
			end
			if (state_q == ST_SWEEP && !sweep_end) begin
				addr_q <= addr_q + 1'b1;
			end
			if (state_q == ST_FLUSH) begin
				clear_q <= 1'b0;
			end
			if (state_q == ST_SPAWN && mod_done) begin
				left_q <= left_q - 8'd1;
				ins_q <= (ins_q == AW'(Slots - 1)) ? '0 : ins_q + 1'b1;
				if (left_q != 8'd1) begin
					rand_q <= rnd_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cx_q <= spawn_x;
			cy_q <= spawn_y;
			ramp_q <= color_ramp;
			spread_q <= speed_spread;
		end
	end

	assign fx = rd_data.pos_x[15:4];
	assign fy = rd_data.pos_y[15:4];
	assign on_screen = !fx[11] && !fy[11]
		&& ($signed({1'b0, fx}) <= $signed({1'b0, width_q}) - 13'sd3)
		&& ($signed({1'b0, fy}) <= $signed({1'b0, height_q}) - 13'sd3);
	assign l3 = 7'(rd_data.life * 3);
	assign s1x = {2'd0, rd_data.start};
	assign s2x = {1'b0, rd_data.start, 1'b0};

	always_comb begin
		wr_en = 1'b0;
		wr_addr = rd_slot_s1;
		wr_data = rd_data;
		if (state_q == ST_SPAWN && mod_done) begin
			wr_en = 1'b1;
			wr_addr = ins_q;
			wr_data.pos_x = 16'({{4{cx_q[11]}}, cx_q} << 4);
			wr_data.pos_y = 16'({{4{cy_q[11]}}, cy_q} << 4);
			wr_data.vel_x = sp_vx;
			wr_data.vel_y = sp_vy;
			wr_data.life = sp_life;
			wr_data.start = sp_life;
			wr_data.ramp = ramp_q;
		end else if (rd_valid_s1) begin
			if (clear_q) begin
				wr_en = 1'b1;
				wr_data = '0;
			end else if (rd_data.life != 5'd0) begin
				if (req_q == REQ_TICK) begin
					wr_en = 1'b1;
					wr_data.life = rd_data.life - 5'd1;
					wr_data.pos_x = rd_data.pos_x + rd_data.vel_x;
					wr_data.pos_y = rd_data.pos_y + rd_data.vel_y;
					wr_data.vel_y = rd_data.vel_y + 16'd2;
				end else if (!on_screen) begin
					wr_en = 1'b1;
					wr_data.life = 5'd0;
				end
			end
		end
	end

	assign emit_now = rd_valid_s1 && !clear_q && req_q == REQ_DRAW
		&& rd_data.life != 5'd0 && on_screen;

	// A found particle is held until the next one is found or the sweep flushes, so the final one can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_pend_q <= 1'b0;
			any_q <= 1'b0;
			strobe <= 1'b0;
			last <= 1'b0;
			visible <= 1'b0;
		end else begin
			strobe <= 1'b0;
			last <= 1'b0;
			if (state_q == ST_IDLE) begin
				any_q <= 1'b0;
			end
			if (emit_now) begin
				has_pend_q <= 1'b1;
				any_q <= 1'b1;
				if (has_pend_q) begin
					strobe <= 1'b1;
					visible <= 1'b1;
				end
			end
			if (state_q == ST_FLUSH && has_pend_q) begin
				strobe <= 1'b1;
				last <= 1'b1;
				visible <= 1'b1;
				has_pend_q <= 1'b0;
			end
			if (state_q == ST_EMPTY) begin
				strobe <= 1'b1;
				last <= 1'b1;
				visible <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			pend_x_q <= fx[10:0];
			pend_y_q <= fy[10:0];
			pend_col_q <= rd_data.ramp + fade_step(rd_data.start, rd_data.life);
			pend_size_q <= (l3 > s2x) ? 2'd3 : ((l3 > s1x) ? 2'd2 : 2'd1);
		end
		if ((emit_now && has_pend_q) || (state_q == ST_FLUSH && has_pend_q)) begin
			pixel_x <= pend_x_q;
			pixel_y <= pend_y_q;
			dot_color <= pend_col_q;
			dot_size <= pend_size_q;
		end else if (state_q == ST_EMPTY) begin
			pixel_x <= '0;
			pixel_y <= '0;
			dot_color <= '0;
			dot_size <= 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe) else $error("last without strobe");
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_IDLE) |-> !strobe)
		else $error("result while idle");
	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMPTY |-> !has_pend_q) else $error("empty with pending result");
	a_ins_range: assert property (@(posedge clk) disable iff (!arst_n)
		ins_q <= AW'(Slots - 1)) else $error("insert slot out of range");
`endif

endmodule
